// File: rtl/tgf_pkg.sv
// Shared types, constants and the sine table builder of the tone generator.
// Used by the divider, the sine ROM and the top level; depends on nothing.
`default_nettype none

package tgf_pkg;

  // sizes
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int COUNT_WIDTH      = 16;
  localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);
  localparam int PHASE_W          = 19;
  localparam int FREQ_W           = 18;
  localparam int WAVE_TYPE_W      = 2;
  localparam int SEED_W           = 16;
  localparam int SINE_W           = 16;
  localparam int MAG_W            = 16;
  localparam int SAMPLE_W         = 15;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 18;

  // arithmetic constants
  localparam int RATE_DECI   = 441000;
  localparam int PHASE_HALF  = RATE_DECI / 2;
  localparam int AMPLITUDE   = 12000;
  localparam int AMP_W       = $clog2(AMPLITUDE + 1);
  localparam int FRAC_SHIFT  = 15;
  localparam int PROD1_W     = MAG_W + AMP_W;
  localparam int PROD2_W     = PROD1_W + COUNT_WIDTH;
  localparam int FULL_SCALE  = 32768;

  // shared divider sizes
  localparam int DIV_W  = (PHASE_W > COUNT_WIDTH) ? PHASE_W : COUNT_WIDTH;
  localparam int QUO_W  = (SINE_ADDR_W > AMP_W) ? SINE_ADDR_W : AMP_W;
  localparam int STEP_W = $clog2(QUO_W + 1);

  // reset values
  localparam int FREQ_RESET  = 8800;
  localparam int COUNT_RESET = 4410;
  localparam int SEED_RESET  = 44257;
  localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_TYPE    = 2'd0,
    REG_FREQUENCY    = 2'd1,
    REG_SAMPLE_COUNT = 2'd2,
    REG_NOISE_SEED   = 2'd3
  } cfg_reg_e;

  // wave codes, code three plays as noise
  typedef enum logic [WAVE_TYPE_W-1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_NOISE  = 2'd2
  } wave_e;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  divisor;
    logic [DIV_W-1:0]  rem;
    logic [QUO_W-1:0]  lo;
    logic [STEP_W-1:0] steps;
  } tgf_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } tgf_div_rsp_t;

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];

  // sine table, Q30 Taylor series folded to the first quadrant
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint unsigned q30_one;
    longint unsigned pi_q30;
    longint unsigned ang;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    logic neg;
    q30_one = 64'd1073741824;
    pi_q30  = 64'd3373259426;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      ang = (64'd2 * pi_q30 * longint'(k)) / SINE_TABLE_DEPTH;
      neg = 1'b0;
      if (ang >= pi_q30) begin
        neg = 1'b1;
        ang = ang - pi_q30;
      end
      if (64'd2 * ang > pi_q30) begin
        ang = pi_q30 - ang;
      end
      x2 = (ang * ang) >> 30;
      t  = q30_one - x2 / 110;
      t  = q30_one - ((x2 * t) >> 30) / 72;
      t  = q30_one - ((x2 * t) >> 30) / 42;
      t  = q30_one - ((x2 * t) >> 30) / 20;
      t  = q30_one - ((x2 * t) >> 30) / 6;
      s  = (ang * t) >> 30;
      v  = (s * 64'd32767 + (q30_one >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[k] = neg ? -SINE_W'(v) : SINE_W'(v);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tgf_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Serves both the sine table address and the faded amplitude; uses tgf_pkg.
`default_nettype none

module tgf_divider
  import tgf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire tgf_div_req_t req_i,
  output tgf_div_rsp_t      rsp_o
);

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  div_q;
  logic [QUO_W-1:0]  lo_q;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIV_W:0]    trial;

  // compare and subtract on the remainder shifted by one bit
  always_comb begin
    trial = {rem_q, lo_q[QUO_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = DIV_W'(trial - {1'b0, div_q});
      quo_d = {quo_q[QUO_W-2:0], 1'b1};
    end else begin
      rem_d = trial[DIV_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], 1'b0};
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem;
      div_q <= req_i.divisor;
      lo_q  <= req_i.lo;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

// File: rtl/tgf_sine_rom.sv
// Sine table ROM with registered read.
// Contents come from the table builder in tgf_pkg.
`default_nettype none

module tgf_sine_rom
  import tgf_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic [SINE_ADDR_W-1:0]   addr_i,
  output logic signed [SINE_W-1:0]      data_o
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // registered read
  always_ff @(posedge clk_i) begin
    data_o <= SINE_ROM[addr_i];
  end

endmodule

`default_nettype wire

// File: rtl/tone_generator_with_fade_top.sv
// Tone generator with linear fade: sequencer, registers, LFSR and multiplier.
// Uses tgf_pkg, tgf_divider and tgf_sine_rom.
//
// One request on the input channel is one 44.1 kHz sample tick; restart_i
// starts the tone anew at sample zero. Each request gives exactly one result
// on the output channel: sample_o, last_o on the final tone sample, and
// active_o while a tone plays (silence gives zeros).
// The block takes one request at a time. A silent tick goes straight to
// the output register; every other tick uses the shared divider, which
// produces one quotient bit per cycle: 10 bits for the sine table address
// (sine only) and 14 bits for the faded value of every tone wave.
// The input is ready again once the result is in the output register, so a
// new request is taken while an earlier result still waits; a stalled
// receiver holds the result and, when the next one is done, the sequencer.
// Configuration writes go straight into the registers and belong to idle
// times; writing the noise seed also reloads the LFSR (a zero seed loads 1).
// Reset: no tone running, index and phase zero, sine wave, 880.0 Hz,
// 4410 samples, LFSR at its default seed, no result pending.
`default_nettype none

module tone_generator_with_fade_top
  import tgf_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data_i,
  // tick requests
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       restart_i,
  // samples
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0]      sample_o,
  output logic                            last_o,
  output logic                            active_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_ROM,
    S_MUL1,
    S_MUL2,
    S_DSTART,
    S_DIV,
    S_OUT
  } state_e;

  state_e                   state_q;
  logic [WAVE_TYPE_W-1:0]   wave_type_q;
  logic [FREQ_W-1:0]        freq_q;
  logic [COUNT_WIDTH-1:0]   count_q;
  logic [SEED_W-1:0]        lfsr_q;
  logic [COUNT_WIDTH-1:0]   index_q;
  logic [PHASE_W-1:0]       phase_q;
  logic                     running_q;
  logic                     silent_q;
  logic                     neg_q;
  logic [MAG_W-1:0]         mag_q;
  logic [PROD1_W-1:0]       prod1_q;
  logic [PROD2_W-1:0]       prod2_q;
  logic [AMP_W-1:0]         res_q;

  logic                     accept;
  logic [COUNT_WIDTH-1:0]   index_n;
  logic [PHASE_W-1:0]       phase_n;
  logic                     run_n;
  logic [COUNT_WIDTH-1:0]   diff;
  logic                     last_n;
  logic [PHASE_W:0]         phase_sum;
  logic [PHASE_W-1:0]       phase_adv;
  logic [SEED_W-1:0]        lfsr_next;
  logic [SEED_W-1:0]        seed_load;
  logic [MAG_W-1:0]         rom_u;
  logic signed [SINE_W-1:0] rom_data;
  tgf_div_req_t             div_req;
  tgf_div_rsp_t             div_rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // tick start: restart and end-of-tone check
  always_comb begin
    index_n = restart_i ? '0 : index_q;
    phase_n = restart_i ? '0 : phase_q;
    run_n   = restart_i ? (count_q != '0) : running_q;
    if (run_n && (index_n >= count_q)) begin
      run_n = 1'b0;
    end
  end

  // fade, last flag and phase advance
  assign diff      = count_q - index_q;
  assign last_n    = ({1'b0, index_q} + (COUNT_WIDTH+1)'(1)) == {1'b0, count_q};
  assign phase_sum = {1'b0, phase_q} + (PHASE_W+1)'(freq_q);
  assign phase_adv = (phase_sum >= (PHASE_W+1)'(RATE_DECI))
                   ? PHASE_W'(phase_sum - (PHASE_W+1)'(RATE_DECI))
                   : phase_sum[PHASE_W-1:0];

  // galois lfsr, shift right
  assign lfsr_next = {1'b0, lfsr_q[SEED_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);
  assign seed_load = (cfg_data_i[SEED_W-1:0] == '0) ? SEED_W'(1) : cfg_data_i[SEED_W-1:0];

  // divider requests: table address, then faded amplitude
  always_comb begin
    div_req = '0;
    if (accept && run_n && (wave_type_q == WAVE_SINE)) begin
      div_req.start   = 1'b1;
      div_req.divisor = DIV_W'(RATE_DECI);
      div_req.rem     = DIV_W'(phase_n);
      div_req.lo      = '0;
      div_req.steps   = STEP_W'(SINE_ADDR_W);
    end else if (state_q == S_DSTART) begin
      div_req.start   = 1'b1;
      div_req.divisor = DIV_W'(count_q);
      div_req.rem     = DIV_W'(prod2_q[PROD2_W-1:FRAC_SHIFT+AMP_W]);
      div_req.lo      = QUO_W'(prod2_q[FRAC_SHIFT+AMP_W-1:FRAC_SHIFT]) << (QUO_W - AMP_W);
      div_req.steps   = STEP_W'(AMP_W);
    end
  end

  tgf_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tgf_sine_rom u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (div_rsp.quo[SINE_ADDR_W-1:0]),
    .data_o (rom_data)
  );

  assign rom_u = rom_data;

  // sequencer, tone state, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wave_type_q <= WAVE_SINE;
      freq_q      <= FREQ_W'(FREQ_RESET);
      count_q     <= COUNT_WIDTH'(COUNT_RESET);
      lfsr_q      <= SEED_W'(SEED_RESET);
      index_q     <= '0;
      phase_q     <= '0;
      running_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && (state_q != S_OUT)) begin
        out_valid_o <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WAVE_TYPE:    wave_type_q <= cfg_data_i[WAVE_TYPE_W-1:0];
          REG_FREQUENCY:    freq_q      <= cfg_data_i[FREQ_W-1:0];
          REG_SAMPLE_COUNT: count_q     <= COUNT_WIDTH'(cfg_data_i[SEED_W-1:0]);
          REG_NOISE_SEED:   lfsr_q      <= seed_load;
          default:          ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            index_q   <= index_n;
            phase_q   <= phase_n;
            running_q <= run_n;
            if (!run_n) begin
              state_q <= S_OUT;
            end else begin
              case (wave_type_q)
                WAVE_SINE: begin
                  state_q <= S_ADDR;
                end
                WAVE_SQUARE: begin
                  state_q <= S_MUL1;
                end
                default: begin
                  lfsr_q  <= lfsr_next;
                  state_q <= S_MUL1;
                end
              endcase
            end
          end
        end
        S_ADDR: begin
          if (div_rsp.done) begin
            state_q <= S_ROM;
          end
        end
        S_ROM:    state_q <= S_MUL1;
        S_MUL1:   state_q <= S_MUL2;
        S_MUL2:   state_q <= S_DSTART;
        S_DSTART: state_q <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
            if (!silent_q) begin
              index_q <= index_q + COUNT_WIDTH'(1);
              phase_q <= phase_adv;
              if (last_n) begin
                running_q <= 1'b0;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath: wave magnitude, two products, result
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          silent_q <= !run_n;
          case (wave_type_q)
            WAVE_SINE: begin
              mag_q <= '0;
              neg_q <= 1'b0;
            end
            WAVE_SQUARE: begin
              mag_q <= MAG_W'(FULL_SCALE);
              neg_q <= !(phase_n < PHASE_W'(PHASE_HALF));
            end
            default: begin
              neg_q <= !lfsr_q[SEED_W-1];
              mag_q <= lfsr_q[SEED_W-1] ? {1'b0, lfsr_q[SEED_W-2:0]}
                                       : MAG_W'((SEED_W+1)'(FULL_SCALE) - {1'b0, lfsr_q});
            end
          endcase
        end
      end
      S_ROM: begin
        neg_q <= rom_u[MAG_W-1];
        mag_q <= rom_u[MAG_W-1] ? (~rom_u + MAG_W'(1)) : rom_u;
      end
      S_MUL1: prod1_q <= PROD1_W'(mag_q) * PROD1_W'(AMPLITUDE);
      S_MUL2: prod2_q <= PROD2_W'(prod1_q) * PROD2_W'(diff);
      S_DIV: begin
        if (div_rsp.done) begin
          res_q <= div_rsp.quo[AMP_W-1:0];
        end
      end
      S_OUT: begin
        if (!out_valid_o || out_ready_i) begin
          if (silent_q) begin
            sample_o <= '0;
            last_o   <= 1'b0;
            active_o <= 1'b0;
          end else begin
            sample_o <= neg_q ? -SAMPLE_W'(res_q) : SAMPLE_W'(res_q);
            last_o   <= last_n;
            active_o <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: verif/tgf_checker.sv
// Sample checker for the tone generator: tracks register writes, predicts each tick's
// sample and compares it with the output channel. Uses tgf_pkg for widths and codes.
`timescale 1ns / 1ps

module tgf_checker
  import tgf_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         restart_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic signed [SAMPLE_W-1:0]   sample_i,
  input  logic                         last_i,
  input  logic                         active_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           checked_o
);

  localparam int unsigned PHASE_WRAP = 441000;
  localparam longint unsigned PEAK   = 64'd12000;
  localparam int Q15_ONE             = 32768;
  localparam longint unsigned Q30    = 64'd1073741824;
  localparam longint unsigned PI_Q30_VAL = 64'd3373259426;
  localparam logic [15:0] NOISE_TAPS = 16'hB400;
  localparam int unsigned COUNT_MASK = (1 << COUNT_WIDTH) - 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       active;
  } tone_sample_t;

  // register copies and tone state
  logic [1:0]  wave_q;
  int unsigned freq_q;
  int unsigned count_q;
  logic [15:0] noise_q;
  int unsigned idx_q;
  int unsigned phase_q;
  logic        run_q;

  int           sine_lut [SINE_TABLE_DEPTH];
  tone_sample_t samples_due_q [$];
  tone_sample_t due;
  int           mismatches;
  int           compared;

  // sin over the first quadrant, angle and result in Q30
  function automatic longint unsigned quarter_sine(input longint unsigned ang);
    longint unsigned sq;
    longint unsigned acc;
    sq  = (ang * ang) >> 30;
    acc = Q30 - sq / 110;
    acc = Q30 - ((sq * acc) >> 30) / 72;
    acc = Q30 - ((sq * acc) >> 30) / 42;
    acc = Q30 - ((sq * acc) >> 30) / 20;
    acc = Q30 - ((sq * acc) >> 30) / 6;
    return (ang * acc) >> 30;
  endfunction

  // one Q15 table entry, folded into the first quadrant
  function automatic int sine_entry(input int k);
    longint unsigned ang;
    longint unsigned mag;
    logic            lower_half;
    ang = (64'd2 * PI_Q30_VAL * longint'(k)) / SINE_TABLE_DEPTH;
    lower_half = ang >= PI_Q30_VAL;
    if (lower_half) ang = ang - PI_Q30_VAL;
    if (64'd2 * ang > PI_Q30_VAL) ang = PI_Q30_VAL - ang;
    mag = (quarter_sine(ang) * 64'd32767 + (Q30 >> 1)) >> 30;
    if (mag > 64'd32767) mag = 64'd32767;
    return lower_half ? -int'(mag) : int'(mag);
  endfunction

  initial begin
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) sine_lut[k] = sine_entry(k);
  end

  // advance the tone by one tick and return the sample it gives
  function automatic tone_sample_t next_tone_sample(input logic restart);
    tone_sample_t    s;
    int              wave_q15;
    int              lut_pos;
    logic            lfsr_out;
    longint unsigned mag;
    longint unsigned quo;
    s = '0;
    if (restart) begin
      idx_q   = 0;
      phase_q = 0;
      run_q   = count_q != 0;
    end
    // shrunk count ends the tone at once
    if (run_q && idx_q >= count_q) run_q = 1'b0;
    if (!run_q) return s;

    if (wave_q == WAVE_SINE) begin
      lut_pos = int'((longint'(phase_q) * SINE_TABLE_DEPTH) / PHASE_WRAP);
      if (lut_pos >= SINE_TABLE_DEPTH) lut_pos = SINE_TABLE_DEPTH - 1;
      wave_q15 = sine_lut[lut_pos];
    end else if (wave_q == WAVE_SQUARE) begin
      wave_q15 = (2 * phase_q < PHASE_WRAP) ? Q15_ONE : -Q15_ONE;
    end else begin
      // noise, code three too; galois shift right
      wave_q15 = int'(noise_q) - Q15_ONE;
      lfsr_out = noise_q[0];
      noise_q  = noise_q >> 1;
      if (lfsr_out) noise_q = noise_q ^ NOISE_TAPS;
    end

    // linear fade, truncated toward zero
    mag = (wave_q15 < 0) ? longint'(-wave_q15) : longint'(wave_q15);
    quo = (mag * PEAK * longint'(count_q - idx_q)) / (longint'(count_q) * Q15_ONE);
    s.sample = (wave_q15 < 0) ? -SAMPLE_W'(quo) : SAMPLE_W'(quo);
    s.last   = (idx_q + 1 == count_q);
    s.active = 1'b1;

    idx_q   = (idx_q + 1) & COUNT_MASK;
    phase_q = phase_q + freq_q;
    if (phase_q >= PHASE_WRAP) phase_q = phase_q - PHASE_WRAP;
    if (s.last) run_q = 1'b0;
    return s;
  endfunction

  // watch writes, requests and samples
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q     = WAVE_SINE;
      freq_q     = 8800;
      count_q    = 4410 & COUNT_MASK;
      noise_q    = 16'd44257;
      idx_q      = 0;
      phase_q    = 0;
      run_q      = 1'b0;
      mismatches = 0;
      compared   = 0;
      samples_due_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_WAVE_TYPE:    wave_q  = cfg_data_i[1:0];
          REG_FREQUENCY:    freq_q  = cfg_data_i;
          REG_SAMPLE_COUNT: count_q = cfg_data_i[15:0] & COUNT_MASK;
          REG_NOISE_SEED:   noise_q = (cfg_data_i[15:0] == 0) ? 16'd1 : cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (samples_due_q.size() == 0) begin
          $error("sample %0d arrived with no tick request waiting", $signed(sample_i));
          mismatches++;
        end else begin
          due = samples_due_q.pop_front();
          compared++;
          if (due.sample !== sample_i) begin
            $error("sample: expected %0d, got %0d", $signed(due.sample), $signed(sample_i));
            mismatches++;
          end
          if (due.last !== last_i) begin
            $error("last: expected %0d, got %0d", due.last, last_i);
            mismatches++;
          end
          if (due.active !== active_i) begin
            $error("active: expected %0d, got %0d", due.active, active_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) samples_due_q.push_back(next_tone_sample(restart_i));
    end
    errors_o  <= mismatches;
    pending_o <= samples_due_q.size();
    checked_o <= compared;
  end

endmodule

// File: verif/tb_tone_generator_with_fade_top.sv
// Testbench top for tone_generator_with_fade_top: clock, reset, tick and register
// stimulus, receiver stalls and the verdict. Uses tgf_pkg and tgf_checker.
`timescale 1ns / 1ps

module tb_tone_generator_with_fade_top;
  import tgf_pkg::*;

  localparam int TICKS_TARGET  = 1300;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int COUNT_MAX     = 65535;
  localparam int FREQ_MAX      = 220500;
  localparam int SEED_MAX      = 65535;

  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       cfg_we     = 1'b0;
  cfg_reg_e                   cfg_idx    = REG_WAVE_TYPE;
  logic [CFG_DATA_W-1:0]      cfg_data   = '0;
  logic                       tick_valid = 1'b0;
  logic                       tick_ready;
  logic                       restart    = 1'b0;
  logic                       smp_valid;
  logic                       smp_ready  = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       active;

  int errors;
  int pending;
  int checked;

  // stimulus bookkeeping
  int ticks_sent   = 0;
  int tone_left    = 0;
  int burst_left   = 0;
  int count_now    = 4410;
  int phases_run   = 0;
  bit gaps_on      = 1'b1;
  int rx_mode      = 1;
  int hold_token   = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int rx_phase     = 0;
  int idle_cycles  = 0;
  logic rx_go;

  always #1 clk_i = ~clk_i;

  tone_generator_with_fade_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (tick_valid),
    .in_ready_o  (tick_ready),
    .restart_i   (restart),
    .out_valid_o (smp_valid),
    .out_ready_i (smp_ready),
    .sample_o    (sample),
    .last_o      (last),
    .active_o    (active)
  );

  tgf_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (tick_valid),
    .in_ready_i  (tick_ready),
    .restart_i   (restart),
    .out_valid_i (smp_valid),
    .out_ready_i (smp_ready),
    .sample_i    (sample),
    .last_i      (last),
    .active_i    (active),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // receiver: stall pattern per phase, plus a long hold on request
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1;
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    case (rx_mode)
      0:       rx_go = 1'b1;
      1:       rx_go = $urandom_range(0, 1);
      2:       rx_go = (rx_phase % 7) >= 3;
      default: rx_go = $urandom_range(0, 9) != 0;
    endcase
    smp_ready <= rx_go && hold_token == hold_seen && hold_left == 0;
  end

  // watchdog on cycles without any accepted request or sample
  always @(posedge clk_i) begin
    if (!rst_ni || (tick_valid && tick_ready) || (smp_valid && smp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or sample accepted for %0d cycles", STALL_LIMIT);
      $display("[tone_generator_with_fade_top] ERROR");
      $finish;
    end
  end

  // offer one tick request, then maybe leave a gap between bursts
  task automatic send_tick(input logic rs);
    tick_valid <= 1'b1;
    restart    <= rs;
    do @(posedge clk_i); while (!tick_ready);
    ticks_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_on) begin
      burst_left = $urandom_range(1, 24);
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every sample due
  task automatic drain();
    tick_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // write enable stays high across back-to-back writes
  task automatic write_reg(input cfg_reg_e r, input int unsigned v);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= CFG_DATA_W'(v);
    if (r == REG_SAMPLE_COUNT) count_now = v;
    @(posedge clk_i);
  endtask

  // mostly whole tones from a restart, sometimes cut short or run into silence
  function automatic logic plan_restart();
    if (tone_left == 0 || $urandom_range(0, 49) == 0) begin
      tone_left = $urandom_range(1, ((count_now > 200) ? 200 : count_now) + 3);
      return 1'b1;
    end
    tone_left--;
    return 1'b0;
  endfunction

  // random register settings, extremes weighted in
  task automatic random_settings();
    if ($urandom_range(0, 2) != 0) write_reg(REG_WAVE_TYPE, $urandom_range(0, 3));
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 5))
        0:       write_reg(REG_FREQUENCY, 0);
        1:       write_reg(REG_FREQUENCY, FREQ_MAX);
        2:       write_reg(REG_FREQUENCY, $urandom_range(0, 2000));
        default: write_reg(REG_FREQUENCY, $urandom_range(0, FREQ_MAX));
      endcase
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 15))
        0:       write_reg(REG_SAMPLE_COUNT, 0);
        1:       write_reg(REG_SAMPLE_COUNT, 1);
        2:       write_reg(REG_SAMPLE_COUNT, COUNT_MAX);
        3:       write_reg(REG_SAMPLE_COUNT, $urandom_range(100, 400));
        default: write_reg(REG_SAMPLE_COUNT, $urandom_range(1, 60));
      endcase
    end
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 7))
        0:       write_reg(REG_NOISE_SEED, 0);
        1:       write_reg(REG_NOISE_SEED, SEED_MAX);
        default: write_reg(REG_NOISE_SEED, $urandom_range(0, SEED_MAX));
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // silence after reset, then the default sine with a restart mid-tone
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);

    // square at the top frequency, two-sample tone then silence
    drain();
    write_reg(REG_WAVE_TYPE, WAVE_SQUARE);
    write_reg(REG_FREQUENCY, FREQ_MAX);
    write_reg(REG_SAMPLE_COUNT, 2);
    cfg_we <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    // noise from a zero seed, frequency zero
    drain();
    write_reg(REG_WAVE_TYPE, WAVE_NOISE);
    write_reg(REG_FREQUENCY, 0);
    write_reg(REG_SAMPLE_COUNT, 3);
    write_reg(REG_NOISE_SEED, 0);
    cfg_we <= 1'b0;
    repeat (4) send_tick(plan_restart() || ticks_sent == 11);

    // wave code three, all-ones seed, longest tone
    drain();
    write_reg(REG_WAVE_TYPE, 3);
    write_reg(REG_NOISE_SEED, SEED_MAX);
    write_reg(REG_SAMPLE_COUNT, COUNT_MAX);
    cfg_we <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b0);

    // zero count starts nothing
    drain();
    write_reg(REG_SAMPLE_COUNT, 0);
    cfg_we <= 1'b0;
    send_tick(1'b1);

    // sine at frequency zero, then the count shrunk under the index
    drain();
    write_reg(REG_WAVE_TYPE, WAVE_SINE);
    write_reg(REG_SAMPLE_COUNT, 5);
    cfg_we <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain();
    write_reg(REG_SAMPLE_COUNT, 2);
    cfg_we <= 1'b0;
    send_tick(1'b0);

    // sine quarter steps
    drain();
    write_reg(REG_FREQUENCY, FREQ_MAX / 2);
    write_reg(REG_SAMPLE_COUNT, 4);
    cfg_we <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    tone_left = 0;

    // random phases with new settings between them
    while (ticks_sent < TICKS_TARGET) begin
      drain();
      random_settings();
      gaps_on = $urandom_range(0, 2) != 0;
      rx_mode <= $urandom_range(0, 3);
      if (phases_run == 3 || phases_run == 17) begin
        gaps_on = 1'b0;
        hold_token <= hold_token + 1;
      end
      repeat ($urandom_range(15, 60)) send_tick(plan_restart());
      phases_run++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d tick requests over %0d random setting phases, %0d samples compared",
             ticks_sent, phases_run, checked);
    $display("all wave codes, counts 0..%0d, zero seed, shrunk counts, %0d-cycle receiver hold",
             COUNT_MAX, LONG_HOLD);
    if (errors == 0 && pending == 0) begin
      $display("[tone_generator_with_fade_top] OK");
    end else begin
      $display("[tone_generator_with_fade_top] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tgf_pkg.sv
rtl/tgf_divider.sv
rtl/tgf_sine_rom.sv
rtl/tone_generator_with_fade_top.sv
verif/tgf_checker.sv
verif/tb_tone_generator_with_fade_top.sv
